// ----- hw/rtl/frfc_pkg.sv -----
// Shared constants for the finite radix fraction check block.
`default_nettype none

package frfc_pkg;

	localparam int RADIX_W = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
	localparam logic [RADIX_W-1:0] FIRST_PRIME = 7'd2;

endpackage : frfc_pkg

`default_nettype wire

// ----- hw/rtl/frfc_div.sv -----
// Iterative restoring divider: one quotient bit per cycle, shared by all steps.
`default_nettype none

module frfc_div #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] dividend,
	input  wire logic [VALUE_WIDTH-1:0] divisor,
	output logic                        done,
	output logic [VALUE_WIDTH-1:0]      quot,
	output logic [VALUE_WIDTH-1:0]      rem
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(VALUE_WIDTH);
	localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] dsr_q;

	logic [VALUE_WIDTH:0]   r_shift;
	logic [VALUE_WIDTH:0]   diff;

	// Shift in the next dividend bit and try a subtract.
	assign r_shift = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff    = r_shift - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= STEPS;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - ONE;
				done_q <= (cnt_q == ONE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!diff[VALUE_WIDTH]) begin
				rem_q <= diff[VALUE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= r_shift[VALUE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule : frfc_div

`default_nettype wire

// ----- hw/rtl/finite_radix_fraction_check_top.sv -----
// Top level of the finite radix fraction check: sequencer around a shared divider.
`default_nettype none

// Decides whether the proper fraction numerator/denominator has a terminating
// expansion in the configured radix. One word goes in on the req channel and
// exactly one result word comes out on the rsp channel. status is 1 when the
// numerator or denominator is zero or the numerator is not below the
// denominator; terminating is then 0. Otherwise the fraction is reduced with
// Euclid's algorithm and every prime factor of the radix is stripped from the
// reduced denominator; terminating is 1 when the denominator ends at 1. All
// remainders and quotients come from one restoring divider, and an item costs
// one division per Euclid step (at most about 1.44 * VALUE_WIDTH), one for
// the reduction, one trial per candidate up to the remaining radix cofactor,
// and one per factor stripped; an invalid fraction uses no division at all.
// req_stall is high from acceptance until the result is loaded into the
// output register, which then waits for the sink while the next word may
// already be accepted. The user must write the radix register (reset 10)
// through cfg_we/cfg_wdata only while the block is idle; the block itself
// does not enforce this. Values below 2 act as 2 and values above 64 act
// as 64.

module finite_radix_fraction_check_top
	import frfc_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [RADIX_W-1:0]     cfg_wdata,
	input  wire logic                   req_valid,
	output logic                        req_stall,
	input  wire logic [VALUE_WIDTH-1:0] numerator,
	input  wire logic [VALUE_WIDTH-1:0] denominator,
	output logic                        rsp_valid,
	input  wire logic                   rsp_stall,
	output logic                        status,
	output logic                        terminating
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_REDUCE,
		ST_PTEST,
		ST_RSTRIP,
		ST_DSTRIP,
		ST_FINISH
	} state_t;

	localparam logic [VALUE_WIDTH-1:0] VAL_ONE = VALUE_WIDTH'(1);

	state_t                 state_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] y_q;
	logic [VALUE_WIDTH-1:0] den_q;
	logic [RADIX_W-1:0]     rest_q;
	logic [RADIX_W-1:0]     p_q;
	logic                   bad_q;
	logic                   div_start_q;
	logic [VALUE_WIDTH-1:0] div_a_q;
	logic [VALUE_WIDTH-1:0] div_b_q;
	logic                   rsp_valid_q;
	logic                   status_q;
	logic                   terminating_q;

	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quot;
	logic [VALUE_WIDTH-1:0] div_rem;

	logic                   req_acc;
	logic                   bad_in;
	logic [RADIX_W-1:0]     base;
	logic [RADIX_W-1:0]     p_next;
	logic                   out_free;
	logic                   rem_zero;
	logic                   div_launch;

	assign req_acc  = req_valid && !req_stall;
	assign bad_in   = (numerator == '0) || (denominator == '0) || (numerator >= denominator);
	assign p_next   = p_q + 7'd1;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rem_zero = (div_rem == '0);

	// Clamp the radix into the supported range.
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			base = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base = RADIX_MAX;
		end else begin
			base = radix_q;
		end
	end

	// Launch the divider whenever the sequencer moves on to another division;
	// prime trials stop once the next candidate passes the radix cofactor.
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				div_launch = req_acc && !bad_in;
			end
			ST_GCD, ST_REDUCE, ST_RSTRIP: begin
				div_launch = div_done;
			end
			ST_PTEST, ST_DSTRIP: begin
				div_launch = div_done && (rem_zero || (p_next <= rest_q));
			end
			default: begin
				div_launch = 1'b0;
			end
		endcase
	end

	frfc_div #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// Sequencer: every arithmetic step is a launch of the shared divider
	// followed by a wait for its done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			div_start_q <= div_launch;
			// Hold a stalled word, drop a taken one, load a finished one.
			rsp_valid_q <= (rsp_valid_q && rsp_stall) || ((state_q == ST_FINISH) && out_free);
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						bad_q  <= bad_in;
						y_q    <= denominator;
						den_q  <= denominator;
						rest_q <= base;
						if (bad_in) begin
							state_q <= ST_FINISH;
						end else begin
							// First Euclid step: numerator mod denominator.
							div_a_q <= numerator;
							div_b_q <= denominator;
							state_q <= ST_GCD;
						end
					end
				end
				ST_GCD: begin
					if (div_done) begin
						y_q <= div_rem;
						if (rem_zero) begin
							// y holds the gcd: divide it out of the denominator.
							div_a_q <= den_q;
							div_b_q <= y_q;
							state_q <= ST_REDUCE;
						end else begin
							div_a_q <= y_q;
							div_b_q <= div_rem;
						end
					end
				end
				ST_REDUCE: begin
					if (div_done) begin
						den_q   <= div_quot;
						p_q     <= FIRST_PRIME;
						div_a_q <= VALUE_WIDTH'(rest_q);
						div_b_q <= VALUE_WIDTH'(FIRST_PRIME);
						state_q <= ST_PTEST;
					end
				end
				ST_PTEST, ST_RSTRIP: begin
					if (div_done) begin
						if (rem_zero) begin
							// p divides the radix cofactor: strip it and try again.
							rest_q  <= div_quot[RADIX_W-1:0];
							div_a_q <= div_quot;
							div_b_q <= VALUE_WIDTH'(p_q);
							state_q <= ST_RSTRIP;
						end else if (state_q == ST_RSTRIP) begin
							// Cofactor is clean of p: now strip p from the denominator.
							div_a_q <= den_q;
							div_b_q <= VALUE_WIDTH'(p_q);
							state_q <= ST_DSTRIP;
						end else if (p_next > rest_q) begin
							state_q <= ST_FINISH;
						end else begin
							p_q     <= p_next;
							div_a_q <= VALUE_WIDTH'(rest_q);
							div_b_q <= VALUE_WIDTH'(p_next);
						end
					end
				end
				ST_DSTRIP: begin
					if (div_done) begin
						if (rem_zero) begin
							den_q   <= div_quot;
							div_a_q <= div_quot;
						end else if (p_next > rest_q) begin
							state_q <= ST_FINISH;
						end else begin
							p_q     <= p_next;
							div_a_q <= VALUE_WIDTH'(rest_q);
							div_b_q <= VALUE_WIDTH'(p_next);
							state_q <= ST_PTEST;
						end
					end
				end
				ST_FINISH: begin
					// Hold until the output register is free, then load the word.
					if (out_free) begin
						status_q      <= bad_q;
						terminating_q <= !bad_q && (den_q == VAL_ONE);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign terminating = terminating_q;

endmodule : finite_radix_fraction_check_top

`default_nettype wire

// ----- hw/rtl/frfc_chk.sv -----
// Port-level checker for the finite radix fraction check, bound to the top level.
`default_nettype none

module frfc_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire logic status,
	input wire logic terminating
);

	// Hold a stalled result word.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(terminating))
		else $error("stalled result word changed");

	// An invalid fraction never reports a finite expansion.
	a_bad_not_finite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> !terminating)
		else $error("invalid status with terminating set");

	// The block goes busy right after taking a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input not stalled after accept");

	// A new result only appears at the end of busy work.
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared while idle");

endmodule : frfc_chk

bind finite_radix_fraction_check_top frfc_chk u_frfc_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.status      (status),
	.terminating (terminating)
);

`default_nettype wire
